/* rtl/rti_pkg.sv */
// shared types, constants and arithmetic helpers for the ray/triangle intersect block
`default_nettype none

package rti_pkg;

    localparam int COORD_W = 32;
    localparam int T_W     = 31;
    localparam int BARY_W  = 17;
    localparam int THR_W   = 31;
    localparam int Q_DEPTH = 16;
    localparam int Q_AW    = 4;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_DET_THR  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] v0_x;
        logic signed [COORD_W-1:0] v0_y;
        logic signed [COORD_W-1:0] v0_z;
        logic signed [COORD_W-1:0] v1_x;
        logic signed [COORD_W-1:0] v1_y;
        logic signed [COORD_W-1:0] v1_z;
        logic signed [COORD_W-1:0] v2_x;
        logic signed [COORD_W-1:0] v2_y;
        logic signed [COORD_W-1:0] v2_z;
    } tri_in_t;

    typedef struct packed {
        logic                      hit;
        logic [T_W-1:0]            hit_t;
        logic [BARY_W-1:0]         bary_u;
        logic [BARY_W-1:0]         bary_v;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } hit_out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic [THR_W-1:0]          det_threshold;
    } ray_cfg_t;

    // clamp a wide signed value to the 32 bit signed range
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [65:0] x);
        logic signed [COORD_W-1:0] r;
        if (x > 66'sh0_0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (x < -66'sh0_0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = x[COORD_W-1:0];
        return r;
    endfunction

    // full signed product of two coordinates
    function automatic logic signed [63:0] smul32(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return p;
    endfunction

endpackage

`default_nettype wire

/* rtl/rti_front.sv */
// front pipeline: edges, cross products, dot products and hit/miss classification
`default_nettype none

module rti_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_take,
    input  rti_pkg::tri_in_t        in_data,
    input  rti_pkg::ray_cfg_t       cfg,
    output logic                    job_valid,
    output logic                    job_hit,
    output logic [65-FRAC_BITS:0]   job_det,
    output logic [65-FRAC_BITS:0]   job_nu,
    output logic [65-FRAC_BITS:0]   job_nv,
    output logic [65-FRAC_BITS:0]   job_nt
);
    import rti_pkg::*;

    localparam int DW = 66 - FRAC_BITS;
    localparam int J[3] = '{1, 2, 0};
    localparam int K[3] = '{2, 0, 1};

    logic signed [COORD_W-1:0] org[3];
    logic signed [COORD_W-1:0] dir[3];

    // stage valids
    logic f0_vld_reg, f1_vld_reg, f2_vld_reg, f3_vld_reg, f4_vld_reg, f5_vld_reg;

    logic signed [COORD_W-1:0] f0_p0_reg[3], f0_p1_reg[3], f0_p2_reg[3];
    logic signed [COORD_W-1:0] f1_e1_reg[3], f1_e2_reg[3], f1_s_reg[3];
    logic signed [COORD_W-1:0] f2_e1_reg[3], f2_e2_reg[3], f2_s_reg[3];
    logic signed [63:0]        f2_ah_reg[3], f2_al_reg[3], f2_bh_reg[3], f2_bl_reg[3];
    logic signed [COORD_W-1:0] f3_e1_reg[3], f3_e2_reg[3], f3_s_reg[3];
    logic signed [COORD_W-1:0] f3_alpha_reg[3], f3_beta_reg[3];
    logic signed [63:0]        f4_pdet_reg[3], f4_pnu_reg[3], f4_pnv_reg[3], f4_pnt_reg[3];
    logic signed [DW-1:0]      f5_det_reg, f5_nu_reg, f5_nv_reg, f5_nt_reg;

    logic signed [65:0]        sum_det, sum_nu, sum_nv, sum_nt;
    logic [THR_W-1:0]          thr_eff;
    logic                      det_low, nu_bad, nv_bad, uv_over, nt_neg;

    assign org[0] = cfg.origin_x;
    assign org[1] = cfg.origin_y;
    assign org[2] = cfg.origin_z;
    assign dir[0] = cfg.dir_x;
    assign dir[1] = cfg.dir_y;
    assign dir[2] = cfg.dir_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_vld_reg <= 1'b0;
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            f3_vld_reg <= 1'b0;
            f4_vld_reg <= 1'b0;
            f5_vld_reg <= 1'b0;
        end
        else
        begin
            f0_vld_reg <= in_take;
            f1_vld_reg <= f0_vld_reg;
            f2_vld_reg <= f1_vld_reg;
            f3_vld_reg <= f2_vld_reg;
            f4_vld_reg <= f3_vld_reg;
            f5_vld_reg <= f4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f0_p0_reg[0] <= in_data.v0_x;
        f0_p0_reg[1] <= in_data.v0_y;
        f0_p0_reg[2] <= in_data.v0_z;
        f0_p1_reg[0] <= in_data.v1_x;
        f0_p1_reg[1] <= in_data.v1_y;
        f0_p1_reg[2] <= in_data.v1_z;
        f0_p2_reg[0] <= in_data.v2_x;
        f0_p2_reg[1] <= in_data.v2_y;
        f0_p2_reg[2] <= in_data.v2_z;
        for (int i = 0; i < 3; i++)
        begin
            // edges and origin offset
            f1_e1_reg[i] <= sat32(66'(f0_p1_reg[i]) - 66'(f0_p0_reg[i]));
            f1_e2_reg[i] <= sat32(66'(f0_p2_reg[i]) - 66'(f0_p0_reg[i]));
            f1_s_reg[i]  <= sat32(66'(org[i]) - 66'(f0_p0_reg[i]));
            // cross product terms: alpha = dir x e2, beta = s x e1
            f2_e1_reg[i] <= f1_e1_reg[i];
            f2_e2_reg[i] <= f1_e2_reg[i];
            f2_s_reg[i]  <= f1_s_reg[i];
            f2_ah_reg[i] <= smul32(dir[J[i]], f1_e2_reg[K[i]]);
            f2_al_reg[i] <= smul32(dir[K[i]], f1_e2_reg[J[i]]);
            f2_bh_reg[i] <= smul32(f1_s_reg[J[i]], f1_e1_reg[K[i]]);
            f2_bl_reg[i] <= smul32(f1_s_reg[K[i]], f1_e1_reg[J[i]]);
            // cross product difference
            f3_e1_reg[i]    <= f2_e1_reg[i];
            f3_e2_reg[i]    <= f2_e2_reg[i];
            f3_s_reg[i]     <= f2_s_reg[i];
            f3_alpha_reg[i] <= sat32(66'(f2_ah_reg[i] >>> FRAC_BITS)
                                     - 66'(f2_al_reg[i] >>> FRAC_BITS));
            f3_beta_reg[i]  <= sat32(66'(f2_bh_reg[i] >>> FRAC_BITS)
                                     - 66'(f2_bl_reg[i] >>> FRAC_BITS));
            // dot product terms
            f4_pdet_reg[i] <= smul32(f3_e1_reg[i], f3_alpha_reg[i]);
            f4_pnu_reg[i]  <= smul32(f3_alpha_reg[i], f3_s_reg[i]);
            f4_pnv_reg[i]  <= smul32(dir[i], f3_beta_reg[i]);
            f4_pnt_reg[i]  <= smul32(f3_e2_reg[i], f3_beta_reg[i]);
        end
        f5_det_reg <= sum_det[DW-1:0];
        f5_nu_reg  <= sum_nu[DW-1:0];
        f5_nv_reg  <= sum_nv[DW-1:0];
        f5_nt_reg  <= sum_nt[DW-1:0];
    end

    always_comb
    begin
        sum_det = 66'(f4_pdet_reg[0] >>> FRAC_BITS) + 66'(f4_pdet_reg[1] >>> FRAC_BITS)
                + 66'(f4_pdet_reg[2] >>> FRAC_BITS);
        sum_nu  = 66'(f4_pnu_reg[0] >>> FRAC_BITS) + 66'(f4_pnu_reg[1] >>> FRAC_BITS)
                + 66'(f4_pnu_reg[2] >>> FRAC_BITS);
        sum_nv  = 66'(f4_pnv_reg[0] >>> FRAC_BITS) + 66'(f4_pnv_reg[1] >>> FRAC_BITS)
                + 66'(f4_pnv_reg[2] >>> FRAC_BITS);
        sum_nt  = 66'(f4_pnt_reg[0] >>> FRAC_BITS) + 66'(f4_pnt_reg[1] >>> FRAC_BITS)
                + 66'(f4_pnt_reg[2] >>> FRAC_BITS);
    end

    // classification; a zero threshold behaves as one
    always_comb
    begin
        thr_eff = (cfg.det_threshold == '0) ? THR_W'(1) : cfg.det_threshold;
        det_low = f5_det_reg < $signed(DW'(thr_eff));
        nu_bad  = f5_nu_reg[DW-1] || (f5_nu_reg > f5_det_reg);
        nv_bad  = f5_nv_reg[DW-1];
        uv_over = ((DW+1)'(f5_nu_reg) + (DW+1)'(f5_nv_reg)) > (DW+1)'(f5_det_reg);
        nt_neg  = f5_nt_reg[DW-1];
    end

    assign job_valid = f5_vld_reg;
    assign job_hit   = !(det_low || nu_bad || nv_bad || uv_over || nt_neg);
    assign job_det   = f5_det_reg;
    assign job_nu    = f5_nu_reg;
    assign job_nv    = f5_nv_reg;
    assign job_nt    = f5_nt_reg;

endmodule

`default_nettype wire

/* rtl/rti_queue.sv */
// short fifo between the front and back pipelines
`default_nettype none

module rti_queue #(
    parameter int W = 201
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] head_data
);
    import rti_pkg::*;

    logic [W-1:0]  data_reg[Q_DEPTH];
    logic [Q_AW:0] wr_ptr_reg, rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            data_reg[wr_ptr_reg[Q_AW-1:0]] <= push_data;
    end

    assign empty     = (wr_ptr_reg == rd_ptr_reg);
    assign head_data = data_reg[rd_ptr_reg[Q_AW-1:0]];

endmodule

`default_nettype wire

/* rtl/rti_div.sv */
// pipelined restoring divider, one quotient bit per stage, saturating quotient
`default_nettype none

module rti_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [65-FRAC_BITS:0] num,
    input  logic [65-FRAC_BITS:0] den,
    output logic [rti_pkg::T_W-1:0] quo
);
    import rti_pkg::*;

    localparam int DW = 66 - FRAC_BITS;
    localparam int NW = DW - 1 + FRAC_BITS;
    localparam int CW = DW - 1 + T_W - FRAC_BITS;

    logic [DW-2:0] r_reg[T_W+1];
    logic [DW-2:0] d_reg[T_W+1];
    logic [T_W-1:0] lo_reg[T_W+1];
    logic [T_W-1:0] q_reg[T_W+1];
    logic           ovf_reg[T_W+1];

    logic [NW-1:0] n_scaled;
    logic          ovf_in;

    // quotient overflows 31 bits exactly when num >= den * 2^(31-frac)
    always_comb
    begin
        n_scaled = {num[DW-2:0], {FRAC_BITS{1'b0}}};
        ovf_in   = CW'(num[DW-2:0]) >= (CW'(den[DW-2:0]) << (T_W - FRAC_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= (DW-1)'(n_scaled >> T_W);
            d_reg[0]   <= den[DW-2:0];
            lo_reg[0]  <= n_scaled[T_W-1:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf_in;
        end
    end

    for (genvar k = 1; k <= T_W; k++)
    begin : g_step
        logic [DW-1:0]  rs;
        logic           ge;
        logic [T_W-1:0] qn;

        always_comb
        begin
            rs = {r_reg[k-1], lo_reg[k-1][T_W-k]};
            ge = rs >= {1'b0, d_reg[k-1]};
            qn = q_reg[k-1];
            qn[T_W-k] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]   <= ge ? (DW-1)'(rs - {1'b0, d_reg[k-1]}) : rs[DW-2:0];
                d_reg[k]   <= d_reg[k-1];
                lo_reg[k]  <= lo_reg[k-1];
                q_reg[k]   <= qn;
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo = ovf_reg[T_W] ? {T_W{1'b1}} : q_reg[T_W];

endmodule

`default_nettype wire

/* rtl/rti_back.sv */
// back pipeline: three dividers, hit point, output register with skid stage
`default_nettype none

module rti_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rti_pkg::ray_cfg_t     cfg,
    input  logic                  job_avail,
    input  logic                  job_hit,
    input  logic [65-FRAC_BITS:0] job_det,
    input  logic [65-FRAC_BITS:0] job_nu,
    input  logic [65-FRAC_BITS:0] job_nv,
    input  logic [65-FRAC_BITS:0] job_nt,
    output logic                  job_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rti_pkg::hit_out_t     out_data
);
    import rti_pkg::*;

    logic adv;
    logic vld_reg[T_W+1];
    logic hit_reg[T_W+1];

    logic [T_W-1:0] quo_u, quo_v, quo_t;

    logic                      m_vld_reg, m_hit_reg;
    logic [T_W-1:0]            m_t_reg;
    logic [BARY_W-1:0]         m_u_reg, m_v_reg;
    logic signed [63:0]        m_prod_reg[3];
    logic signed [COORD_W-1:0] org[3];
    logic signed [COORD_W-1:0] dir[3];

    logic      a_vld_reg;
    hit_out_t  a_data_reg;
    hit_out_t  a_next;

    logic      out_vld_reg, skid_vld_reg;
    hit_out_t  out_data_reg, skid_data_reg;
    logic      push, take;

    assign org[0] = cfg.origin_x;
    assign org[1] = cfg.origin_y;
    assign org[2] = cfg.origin_z;
    assign dir[0] = cfg.dir_x;
    assign dir[1] = cfg.dir_y;
    assign dir[2] = cfg.dir_z;

    // whole back pipeline moves while the skid stage is free
    assign adv     = !skid_vld_reg;
    assign job_pop = adv && job_avail;

    rti_div #(.FRAC_BITS(FRAC_BITS)) u_div_u (
        .clk (clk), .en (adv), .num (job_nu), .den (job_det), .quo (quo_u)
    );
    rti_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (
        .clk (clk), .en (adv), .num (job_nv), .den (job_det), .quo (quo_v)
    );
    rti_div #(.FRAC_BITS(FRAC_BITS)) u_div_t (
        .clk (clk), .en (adv), .num (job_nt), .den (job_det), .quo (quo_t)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= T_W; k++)
                vld_reg[k] <= 1'b0;
            m_vld_reg <= 1'b0;
            a_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= job_pop;
            for (int k = 1; k <= T_W; k++)
                vld_reg[k] <= vld_reg[k-1];
            m_vld_reg <= vld_reg[T_W];
            a_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg[0] <= job_hit;
            for (int k = 1; k <= T_W; k++)
                hit_reg[k] <= hit_reg[k-1];
            m_hit_reg <= hit_reg[T_W];
            m_t_reg   <= quo_t;
            m_u_reg   <= quo_u[BARY_W-1:0];
            m_v_reg   <= quo_v[BARY_W-1:0];
            for (int i = 0; i < 3; i++)
                m_prod_reg[i] <= smul32($signed({1'b0, quo_t}), dir[i]);
            a_data_reg <= a_next;
        end
    end

    // a miss clears every field
    always_comb
    begin
        a_next = '0;
        if (m_hit_reg)
        begin
            a_next.hit     = 1'b1;
            a_next.hit_t   = m_t_reg;
            a_next.bary_u  = m_u_reg;
            a_next.bary_v  = m_v_reg;
            a_next.point_x = sat32(66'(org[0]) + 66'(m_prod_reg[0] >>> FRAC_BITS));
            a_next.point_y = sat32(66'(org[1]) + 66'(m_prod_reg[1] >>> FRAC_BITS));
            a_next.point_z = sat32(66'(org[2]) + 66'(m_prod_reg[2] >>> FRAC_BITS));
        end
    end

    assign push = a_vld_reg && adv;
    assign take = out_vld_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || take)
        begin
            out_vld_reg  <= skid_vld_reg || push;
            skid_vld_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || take)
            out_data_reg <= skid_vld_reg ? skid_data_reg : a_data_reg;
        else if (push)
            skid_data_reg <= a_data_reg;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/ray_triangle_intersect.sv */
// top level: one-sided ray/triangle intersection of a configured ray against a triangle stream
//
//  channel  dir  handshake                  word
//  in       in   in_valid / in_ready        rti_pkg::tri_in_t, three vertices
//  out      out  out_valid / out_ready      rti_pkg::hit_out_t, hit, t, u, v, point
//  cfg      in   cfg_wr_en, no wait         cfg_index selects register, cfg_data value
//
//  one triangle per clock sustained while out_ready stays high
//  most of the pipeline depth lies in the three 31-stage dividers (one quotient bit per stage)
//  front pipeline never stalls; in_ready drops only when words in the front plus
//  the 16-entry queue would exceed the queue depth
//  back pipeline stalls as a whole when the output skid stage is full
//  asynchronous active-low reset clears control; ray registers reset to origin 0,
//  direction +z, threshold 1
`default_nettype none

module ray_triangle_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rti_pkg::tri_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rti_pkg::hit_out_t out_data,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import rti_pkg::*;

    localparam int DW = 66 - FRAC_BITS;
    localparam int JW = 1 + 4 * DW;

    // ray configuration
    ray_cfg_t cfg_reg;

    // words accepted but not yet popped from the queue
    logic [Q_AW:0] occ_reg, occ_next;

    logic          in_take;
    logic          job_valid, job_hit, job_pop, q_empty;
    logic [DW-1:0] job_det, job_nu, job_nv, job_nt;
    logic [JW-1:0] q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{origin_x: '0, origin_y: '0, origin_z: '0,
                         dir_x: '0, dir_y: '0, dir_z: 32'sh0001_0000,
                         det_threshold: THR_W'(1)};
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X: cfg_reg.origin_x      <= cfg_data;
                REG_ORIGIN_Y: cfg_reg.origin_y      <= cfg_data;
                REG_ORIGIN_Z: cfg_reg.origin_z      <= cfg_data;
                REG_DIR_X:    cfg_reg.dir_x         <= cfg_data;
                REG_DIR_Y:    cfg_reg.dir_y         <= cfg_data;
                REG_DIR_Z:    cfg_reg.dir_z         <= cfg_data;
                REG_DET_THR:  cfg_reg.det_threshold <= cfg_data[THR_W-1:0];
                default:      ;  // unknown index, write dropped
            endcase
        end
    end

    // credit count keeps the queue from overflowing
    assign in_ready = (occ_reg < (Q_AW+1)'(Q_DEPTH));
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        occ_next = occ_reg;
        if (in_take && !job_pop)
            occ_next = occ_reg + 1'b1;
        else if (!in_take && job_pop)
            occ_next = occ_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    rti_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job_hit   (job_hit),
        .job_det   (job_det),
        .job_nu    (job_nu),
        .job_nv    (job_nv),
        .job_nt    (job_nt)
    );

    rti_queue #(.W(JW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_valid),
        .push_data ({job_hit, job_det, job_nu, job_nv, job_nt}),
        .pop       (job_pop),
        .empty     (q_empty),
        .head_data (q_head)
    );

    // queue word layout: hit, det, nu, nv, nt from msb down
    rti_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_avail (!q_empty),
        .job_hit   (q_head[JW-1]),
        .job_det   (q_head[4*DW-1:3*DW]),
        .job_nu    (q_head[3*DW-1:2*DW]),
        .job_nv    (q_head[2*DW-1:DW]),
        .job_nt    (q_head[DW-1:0]),
        .job_pop   (job_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= (Q_AW+1)'(Q_DEPTH))
        else $error("credit count above queue depth");

    a_empty_when_no_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0) |-> q_empty)
        else $error("queue holds words that were never accepted");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.hit) |->
            (out_data.hit_t == '0 && out_data.bary_u == '0 && out_data.bary_v == '0 &&
             out_data.point_x == '0 && out_data.point_y == '0 && out_data.point_z == '0))
        else $error("miss word carries nonzero fields");
`endif

endmodule

`default_nettype wire

/* sim/ray_triangle_intersect_test.sv */
// self-checking testbench for the ray/triangle intersect block, fixed-point predictor and scoreboard
`default_nettype none

module ray_triangle_intersect_test;

    import rti_pkg::*;

    localparam int        FRAC     = 16;
    localparam longint    ONE_Q    = 64'sd65536;
    localparam longint    T_SAT    = 64'sd2147483647;
    localparam int        SETTLE   = 60;      // a bit more than the whole pipeline
    localparam logic [2:0] REG_UNUSED = 3'd7; // index with no register behind it

    typedef struct packed {
        longint x;
        longint y;
        longint z;
    } vec3_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    tri_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    hit_out_t out_data;
    logic     cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // local copy of the ray registers, kept in step with every write
    ray_cfg_t ray;

    // predicted words, oldest first
    hit_out_t expected_hits[$];
    int       error_count;

    // sender and receiver idling controls
    bit send_idle;
    bit recv_idle;
    bit long_hold;

    ray_triangle_intersect #(.FRAC_BITS(FRAC)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // ---------------------------------------------------------------
    // fixed-point predictor
    // ---------------------------------------------------------------

    function automatic longint clamp_s32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // product scaled back by the fraction bits, rounding toward minus infinity
    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return p >>> FRAC;
    endfunction

    function automatic vec3_t edge_of(input vec3_t a, input vec3_t b);
        vec3_t r;
        r.x = clamp_s32(a.x - b.x);
        r.y = clamp_s32(a.y - b.y);
        r.z = clamp_s32(a.z - b.z);
        return r;
    endfunction

    function automatic vec3_t cross_q(input vec3_t a, input vec3_t b);
        vec3_t r;
        r.x = clamp_s32(qmul(a.y, b.z) - qmul(a.z, b.y));
        r.y = clamp_s32(qmul(a.z, b.x) - qmul(a.x, b.z));
        r.z = clamp_s32(qmul(a.x, b.y) - qmul(a.y, b.x));
        return r;
    endfunction

    // dot product summed exactly, no clamping
    function automatic longint dot_q(input vec3_t a, input vec3_t b);
        return qmul(a.x, b.x) + qmul(a.y, b.y) + qmul(a.z, b.z);
    endfunction

    // n/d with fraction bits, truncated, clamped to the largest distance
    function automatic longint ratio_q(input longint n, input longint d);
        longint unsigned ip;
        longint unsigned rem;
        longint unsigned fr;
        longint unsigned q;
        ip  = longint'(n) / longint'(d);
        rem = longint'(n) % longint'(d);
        if (ip > (T_SAT >> FRAC))
            return T_SAT;
        fr = 0;
        for (int i = 0; i < FRAC; i++)
        begin
            rem = rem << 1;
            fr  = fr << 1;
            if (rem >= d)
            begin
                rem = rem - d;
                fr  = fr | 1;
            end
        end
        q = (ip << FRAC) | fr;
        return (q > T_SAT) ? T_SAT : longint'(q);
    endfunction

    function automatic hit_out_t predict_hit(input tri_in_t tr);
        vec3_t    p0, p1, p2, org, dir, e1, e2, s, alpha, beta;
        longint   det, nu, nv, nt, thr, t, u, v;
        hit_out_t r;
        r = '0;
        p0  = '{longint'(tr.v0_x), longint'(tr.v0_y), longint'(tr.v0_z)};
        p1  = '{longint'(tr.v1_x), longint'(tr.v1_y), longint'(tr.v1_z)};
        p2  = '{longint'(tr.v2_x), longint'(tr.v2_y), longint'(tr.v2_z)};
        org = '{longint'(ray.origin_x), longint'(ray.origin_y), longint'(ray.origin_z)};
        dir = '{longint'(ray.dir_x), longint'(ray.dir_y), longint'(ray.dir_z)};
        e1    = edge_of(p1, p0);
        e2    = edge_of(p2, p0);
        alpha = cross_q(dir, e2);
        det   = dot_q(e1, alpha);
        // zero threshold behaves as one: determinant must be positive
        thr = longint'({1'b0, ray.det_threshold});
        if (thr < 1)
            thr = 1;
        if (det < thr)
            return r;
        s  = edge_of(org, p0);
        nu = dot_q(alpha, s);
        if (nu < 0 || nu > det)
            return r;
        beta = cross_q(s, e1);
        nv   = dot_q(dir, beta);
        if (nv < 0 || nu + nv > det)
            return r;
        nt = dot_q(e2, beta);
        if (nt < 0)
            return r;
        u = ratio_q(nu, det);
        v = ratio_q(nv, det);
        t = ratio_q(nt, det);
        r.hit    = 1'b1;
        r.hit_t  = t[T_W-1:0];
        r.bary_u = u[BARY_W-1:0];
        r.bary_v = v[BARY_W-1:0];
        // hit point uses the clamped distance
        r.point_x = 32'(clamp_s32(org.x + qmul(t, dir.x)));
        r.point_y = 32'(clamp_s32(org.y + qmul(t, dir.y)));
        r.point_z = 32'(clamp_s32(org.z + qmul(t, dir.z)));
        return r;
    endfunction

    // ---------------------------------------------------------------
    // mismatch reporting and the output scoreboard
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        hit_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_hits.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                want = expected_hits.pop_front();
                if (out_data.hit !== want.hit)
                    report_mismatch("hit", out_data.hit, want.hit);
                if (out_data.hit_t !== want.hit_t)
                    report_mismatch("hit_t", out_data.hit_t, want.hit_t);
                if (out_data.bary_u !== want.bary_u)
                    report_mismatch("bary_u", out_data.bary_u, want.bary_u);
                if (out_data.bary_v !== want.bary_v)
                    report_mismatch("bary_v", out_data.bary_v, want.bary_v);
                if (out_data.point_x !== want.point_x)
                    report_mismatch("point_x", out_data.point_x, want.point_x);
                if (out_data.point_y !== want.point_y)
                    report_mismatch("point_y", out_data.point_y, want.point_y);
                if (out_data.point_z !== want.point_z)
                    report_mismatch("point_z", out_data.point_z, want.point_z);
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (recv_idle && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            if (long_hold)
            begin
                // long enough for the queue to fill and in_ready to drop
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // one triangle word; valid stays high so back-to-back words need no drop
    task automatic send_tri(input tri_in_t tr);
        if (send_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= tr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_hits.push_back(predict_hit(tr));
    endtask

    // drop valid, then wait out every expected word plus the pipeline
    task automatic drain;
        in_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_ORIGIN_X: ray.origin_x      = value;
            REG_ORIGIN_Y: ray.origin_y      = value;
            REG_ORIGIN_Z: ray.origin_z      = value;
            REG_DIR_X:    ray.dir_x         = value;
            REG_DIR_Y:    ray.dir_y         = value;
            REG_DIR_Z:    ray.dir_z         = value;
            REG_DET_THR:  ray.det_threshold = value[THR_W-1:0];
            default: ;  // ignored by the block
        endcase
    endtask

    // load a whole ray; only called with the pipeline empty
    task automatic load_ray(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                            input logic [31:0] dx, input logic [31:0] dy, input logic [31:0] dz,
                            input logic [31:0] thr);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
        write_reg(REG_DET_THR, thr);
        cfg_wr_en <= 1'b0;
    endtask

    // triangle from whole-unit coordinates
    function automatic tri_in_t tri_units(input int ax, input int ay, input int az,
                                          input int bx, input int by, input int bz,
                                          input int cx, input int cy, input int cz);
        tri_in_t tr;
        tr.v0_x = 32'(ax * ONE_Q);  tr.v0_y = 32'(ay * ONE_Q);  tr.v0_z = 32'(az * ONE_Q);
        tr.v1_x = 32'(bx * ONE_Q);  tr.v1_y = 32'(by * ONE_Q);  tr.v1_z = 32'(bz * ONE_Q);
        tr.v2_x = 32'(cx * ONE_Q);  tr.v2_y = 32'(cy * ONE_Q);  tr.v2_z = 32'(cz * ONE_Q);
        return tr;
    endfunction

    function automatic tri_in_t noise_tri;
        tri_in_t tr;
        tr = {$urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
        return tr;
    endfunction

    // triangle placed across the ray at a random distance; winding fixed to front face
    function automatic tri_in_t aimed_tri;
        longint  t, r, c[3], o[3], d[3];
        tri_in_t tr, swapped;
        t = $urandom_range(0, 64 << FRAC);
        r = $urandom_range(1 << 10, 1 << 22);
        o = '{longint'(ray.origin_x), longint'(ray.origin_y), longint'(ray.origin_z)};
        d = '{longint'(ray.dir_x), longint'(ray.dir_y), longint'(ray.dir_z)};
        for (int k = 0; k < 3; k++)
            c[k] = clamp_s32(o[k] + qmul(t, d[k]));
        tr.v0_x = 32'(clamp_s32(c[0] - r + $urandom_range(0, r / 2)));
        tr.v0_y = 32'(clamp_s32(c[1] - r + $urandom_range(0, r / 2)));
        tr.v0_z = 32'(clamp_s32(c[2] - longint'($urandom_range(0, r))));
        tr.v1_x = 32'(clamp_s32(c[0] + r - $urandom_range(0, r / 2)));
        tr.v1_y = 32'(clamp_s32(c[1] - r + $urandom_range(0, r)));
        tr.v1_z = 32'(clamp_s32(c[2] + longint'($urandom_range(0, r))));
        tr.v2_x = 32'(clamp_s32(c[0] - r + $urandom_range(0, r)));
        tr.v2_y = 32'(clamp_s32(c[1] + r - $urandom_range(0, r / 2)));
        tr.v2_z = 32'(clamp_s32(c[2] + longint'($urandom_range(0, r)) - r / 2));
        swapped = tr;
        swapped.v1_x = tr.v2_x;  swapped.v1_y = tr.v2_y;  swapped.v1_z = tr.v2_z;
        swapped.v2_x = tr.v1_x;  swapped.v2_y = tr.v1_y;  swapped.v2_z = tr.v1_z;
        if (!predict_hit(tr).hit && predict_hit(swapped).hit)
            return swapped;
        return tr;
    endfunction

    // mostly aimed triangles, some flipped to back face, some pure noise
    task automatic send_mix(input int count);
        tri_in_t tr;
        logic [31:0] tmp;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    tr = noise_tri();
                2:
                begin
                    tr = aimed_tri();
                    tmp = tr.v1_x;  tr.v1_x = tr.v2_x;  tr.v2_x = tmp;
                    tmp = tr.v1_y;  tr.v1_y = tr.v2_y;  tr.v2_y = tmp;
                    tmp = tr.v1_z;  tr.v1_z = tr.v2_z;  tr.v2_z = tmp;
                end
                default:
                    tr = aimed_tri();
            endcase
            send_tri(tr);
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // ray from reset: origin 0 looking down +z
    task automatic test_directed_reset_ray;
        send_tri(tri_units(-1, -1, 5, -1, 1, 5, 1, -1, 5));   // plain front-face hit
        send_tri(tri_units(-1, -1, 5, 1, -1, 5, -1, 1, 5));   // same triangle, back face
        send_tri(tri_units(0, 0, 5, -1, 1, 5, 1, -1, 5));     // vertex on the ray, but vertices in a line, det 0
        send_tri(tri_units(-1, -1, 5, 1, 1, 5, 1, -1, 5));    // ray on the v0-v1 edge, v = 0
        send_tri(tri_units(-2, 0, 5, -2, 2, 5, 0, -2, 5));    // ray just past the v1-v2 edge, u + v = 2
        send_tri(tri_units(1, 1, 5, 1, 3, 5, 3, 1, 5));       // beside the ray
        send_tri(tri_units(-1, -1, -5, -1, 1, -5, 1, -1, -5)); // behind origin, t < 0
        send_tri(tri_units(-1, -1, 0, -1, 1, 0, 1, -1, 0));   // t = 0
        send_tri(tri_units(-1, -1, 5, -1, 1, 9, 1, -1, 2));   // slanted plane
        send_tri(tri_units(3, 3, 5, 3, 3, 5, 3, 3, 5));       // degenerate, det 0
        send_tri('0);
        send_tri('1);
        send_tri({9{32'h7FFF_FFFF}});
        send_tri({9{32'h8000_0000}});
        send_tri({32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001});
        send_tri({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        drain();
    endtask

    // threshold edges: zero acts as one, largest value rejects almost everything
    task automatic test_threshold;
        load_ray(0, 0, 0, 0, 0, 32'h0001_0000, 32'h0000_0000);
        send_tri(tri_units(-1, -1, 5, -1, 1, 5, 1, -1, 5));
        send_tri(tri_units(0, 0, 5, 0, 0, 5, 0, 0, 5));
        send_tri({32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0001, 32'h0,
                  32'hFFFF_FFFF, 32'h0, 32'h0});
        send_mix(20);
        drain();
        write_reg(REG_DET_THR, 32'h7FFF_FFFF);
        cfg_wr_en <= 1'b0;
        send_tri(tri_units(-1, -1, 5, -1, 1, 5, 1, -1, 5));
        send_tri(tri_units(-30000, -30000, 5, -30000, 30000, 5, 30000, -30000, 5));
        send_mix(15);
        drain();
        // top bit of the data word has no place in the 31-bit register
        write_reg(REG_DET_THR, 32'h8000_0004);
        cfg_wr_en <= 1'b0;
        send_tri(tri_units(-1, -1, 5, -1, 1, 5, 1, -1, 5));
        send_mix(10);
        drain();
    endtask

    // tiny direction makes t huge, so distance and point clamp
    task automatic test_large_distance;
        load_ray(0, 0, 0, 0, 0, 32'h0000_0001, 32'h0000_0001);
        send_tri(tri_units(-1, -1, 100, -1, 1, 100, 1, -1, 100));
        send_tri(tri_units(-1, -1, 30000, -1, 1, 30000, 1, -1, 30000));
        drain();
        load_ray(32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_mix(20);
        drain();
    endtask

    // writes to a missing index must leave the ray alone
    task automatic test_unused_index;
        load_ray(32'h0001_0000, 32'hFFFF_0000, 0, 0, 0, 32'h0001_0000, 32'h0000_0010);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        cfg_wr_en <= 1'b0;
        send_tri(tri_units(0, -2, 4, 0, 0, 4, 2, -2, 4));
        send_mix(10);
        drain();
    endtask

    // random rays, each followed by a stream of aimed and noise triangles
    task automatic test_random_rays(input int rays, input int per_ray);
        for (int k = 0; k < rays; k++)
        begin
            load_ray($urandom_range(0, 1 << 25) - (1 << 24),
                     $urandom_range(0, 1 << 25) - (1 << 24),
                     $urandom_range(0, 1 << 25) - (1 << 24),
                     $urandom_range(0, 1 << 18) - (1 << 17),
                     $urandom_range(0, 1 << 18) - (1 << 17),
                     $urandom_range(0, 1 << 18) - (1 << 17),
                     $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64));
            send_mix(per_ray);
            drain();
        end
    endtask

    // receiver holds off while triangles keep coming, filling the block
    task automatic test_backpressure;
        load_ray(0, 0, 0, 32'h0000_4000, 32'hFFFF_C000, 32'h0001_0000, 32'h0000_0001);
        long_hold = 1'b1;
        send_idle = 1'b0;
        send_mix(80);
        send_idle = 1'b1;
        drain();
    endtask

    initial
    begin
        error_count = 0;
        send_idle   = 1'b1;
        recv_idle   = 1'b1;
        long_hold   = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_ORIGIN_X;
        cfg_data    = '0;
        ray         = '{origin_x: 0, origin_y: 0, origin_z: 0,
                        dir_x: 0, dir_y: 0, dir_z: 32'sh0001_0000, det_threshold: 1};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_reset_ray();
        test_threshold();
        test_large_distance();
        test_unused_index();
        test_random_rays(6, 40);
        test_backpressure();
        // last stretch runs with no idling on either side
        send_idle = 1'b0;
        recv_idle = 1'b0;
        test_random_rays(2, 60);

        if (error_count == 0)
            $display("ray_triangle_intersect regression: pass");
        else
            $display("ray_triangle_intersect regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #(12 * 400000);
        $display("ray_triangle_intersect regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
